// ===== src/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line-follower PID drive core.
// Used by the channel interfaces, the shared multiplier and the top level.

package lfpd_pkg;

    // Vehicle constants.
    localparam int DRIVE_MAX   = 1999;
    localparam int LAP_COUNTS  = 43000;
    localparam int ALERT_TICKS = 200;

    // Line-loss thresholds in ticks.
    localparam int LOST_SHORT  = 30;
    localparam int LOST_MED    = 100;
    localparam int LOST_LONG   = 120;
    localparam int SCALE_SPLIT = (LOST_SHORT + LOST_MED) / 2;
    localparam int SCALE_NEAR  = 70;
    localparam int SCALE_FAR   = 50;

    localparam int INTEG_LIM   = 500;
    localparam int DRIVE_FLOOR = 100;
    localparam int GAIN_LIM    = 999;

    // Field widths.
    localparam int SENSOR_W = 8;
    localparam int DELTA_W  = 16;
    localparam int DRIVE_W  = 13;
    localparam int ERR_W    = 7;
    localparam int BASE_W   = 12;
    localparam int GAIN_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Distance accumulator saturates at four laps.
    localparam int DIST_CAP   = 4 * LAP_COUNTS;
    localparam int DIST_W     = $clog2(DIST_CAP + 1);
    localparam int DIST_SUM_W = $clog2(DIST_CAP + 2 * (2 ** (DELTA_W - 1)) + 1);

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 20;
    localparam int PROD_W = 2 * MUL_W;

    // Reciprocals for exact truncating division of bounded magnitudes.
    localparam int SHIFT_CNT  = 16;
    localparam int SHIFT10    = 19;
    localparam int SHIFT10K   = 32;
    localparam int SHIFT100   = 26;
    localparam longint RECIP10   = ((64'd1 << SHIFT10) + 9) / 10;
    localparam longint RECIP10K  = ((64'd1 << SHIFT10K) + 9999) / 10000;
    localparam longint RECIP100  = ((64'd1 << SHIFT100) + 99) / 100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DRIVE   = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_TWO_LAP_MODE = 3'd4
    } cfg_index_t;

    // Line status codes.
    typedef enum logic [1:0] {
        ST_ON_LINE = 2'd0,
        ST_SHORT   = 2'd1,
        ST_MEDIUM  = 2'd2,
        ST_LONG    = 2'd3
    } line_status_t;

    // Sensor weights from the leftmost sensor to the rightmost.
    localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [SENSOR_W] = '{
        -7'sd40, -7'sd28, -7'sd20, -7'sd15, 7'sd15, 7'sd20, 7'sd28, 7'sd40
    };

    // Rounded-up 2^16 / count for the weighted-average divide.
    function automatic logic [SHIFT_CNT:0] cnt_recip(input logic [3:0] cnt);
        logic [SHIFT_CNT:0] r;
        unique case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/lfpd_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one sensor sample and the encoder deltas per control tick.
// Depends on lfpd_pkg for field widths.

interface lfpd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [lfpd_pkg::SENSOR_W-1:0]         sensor_bits;
    logic                                  read_failed;
    logic signed [lfpd_pkg::DELTA_W-1:0]   left_delta;
    logic signed [lfpd_pkg::DELTA_W-1:0]   right_delta;

    modport source (
        output valid, sensor_bits, read_failed, left_delta, right_delta,
        input  ready
    );

    modport sink (
        input  valid, sensor_bits, read_failed, left_delta, right_delta,
        output ready
    );
endinterface

// ===== src/lfpd_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: wheel drives and status for one control tick.
// Depends on lfpd_pkg for field widths.

interface lfpd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lfpd_pkg::DRIVE_W-1:0]   left_drive;
    logic signed [lfpd_pkg::DRIVE_W-1:0]   right_drive;
    logic                                  motor_stop;
    logic [1:0]                            line_status;
    logic                                  run_finished;
    logic                                  alert_on;
    logic                                  notify_stop;
    logic signed [lfpd_pkg::ERR_W-1:0]     line_error;

    modport source (
        output valid, left_drive, right_drive, motor_stop, line_status,
               run_finished, alert_on, notify_stop, line_error,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive, motor_stop, line_status,
               run_finished, alert_on, notify_stop, line_error,
        output ready
    );
endinterface

// ===== src/lfpd_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on lfpd_pkg for operand widths.

module lfpd_mul (
    input  logic                         clk,
    input  logic [lfpd_pkg::MUL_W-1:0]   op_a,
    input  logic [lfpd_pkg::MUL_W-1:0]   op_b,
    output logic [lfpd_pkg::PROD_W-1:0]  prod
);

    logic [lfpd_pkg::PROD_W-1:0] prod_reg;

    // One product per cycle, available in the following cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= lfpd_pkg::PROD_W'(op_a) * lfpd_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== src/line_follow_pid_drive_core.sv =====
`timescale 1ns / 1ps
// Line-follower PID drive core: one result per accepted control tick.
// Halted, failed, long-loss and lap-end ticks go from the decide step straight to the finish
// step; normal ticks pass the PID multiply and divide steps, and medium-loss ticks also scale both drives.
// One tick is processed at a time through a single shared multiplier; the next
// transfer is taken the cycle after the result register is loaded, and a tick waits in the
// finish step while the previous result has not yet left.
// Reset (rst_n low, asynchronous) clears all control state and loads register defaults.

module line_follow_pid_drive_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_data,
    lfpd_in_if.sink                              in_ch,
    lfpd_out_if.source                           out_ch
);

    localparam int MW = lfpd_pkg::MUL_W;
    localparam int PW = lfpd_pkg::PROD_W;
    localparam int DW = lfpd_pkg::DIST_W;
    localparam int SW = lfpd_pkg::DIST_SUM_W;

    localparam logic signed [15:0] DRV_HI    = 16'(lfpd_pkg::DRIVE_MAX);
    localparam logic signed [15:0] DRV_LO    = -16'(lfpd_pkg::DRIVE_MAX);
    localparam logic signed [15:0] DRV_FLOOR = 16'(lfpd_pkg::DRIVE_FLOOR);
    localparam logic signed [11:0] INT_HI    = 12'(lfpd_pkg::INTEG_LIM);
    localparam logic signed [11:0] INT_LO    = -12'(lfpd_pkg::INTEG_LIM);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_P_MUL,
        S_P_DIV,
        S_I_MUL,
        S_I_DIV,
        S_D_MUL,
        S_D_DIV,
        S_SUM,
        S_L_MUL,
        S_L_DIV,
        S_R_MUL,
        S_R_DIV,
        S_R_END,
        S_FINISH
    } state_t;

    // Clamp a drive to the limit and lift small forward drives to the floor.
    function automatic logic signed [lfpd_pkg::DRIVE_W-1:0] finish_drive(
        input logic signed [15:0] v
    );
        logic signed [15:0] c;
        if (v > DRV_HI)
            c = DRV_HI;
        else if (v < DRV_LO)
            c = DRV_LO;
        else if (v > 16'sd0 && v < DRV_FLOOR)
            c = DRV_FLOOR;
        else
            c = v;
        return c[lfpd_pkg::DRIVE_W-1:0];
    endfunction

    // Configuration registers.
    logic [lfpd_pkg::BASE_W-1:0]  base_reg;
    logic [lfpd_pkg::GAIN_W-1:0]  gp_reg;
    logic [lfpd_pkg::GAIN_W-1:0]  gi_reg;
    logic [lfpd_pkg::GAIN_W-1:0]  gd_reg;
    logic                         two_lap_reg;

    // Persistent controller state.
    logic signed [6:0]   prev_reg;
    logic signed [10:0]  integ_reg;
    logic [6:0]          lost_reg;
    logic [DW-1:0]       dist_reg;
    logic                given_reg;
    logic                ended_reg;
    logic [7:0]          alert_ticks_reg;
    logic                halted_reg;

    // Latched input item.
    logic [7:0]          bits_reg;
    logic                fail_reg;
    logic signed [15:0]  dl_reg;
    logic signed [15:0]  dr_reg;

    // Per-tick working registers.
    state_t                   state_reg;
    logic signed [6:0]        err_reg;
    lfpd_pkg::line_status_t   status_reg;
    logic signed [7:0]        diff_reg;
    logic [12:0]              p_reg;
    logic [5:0]               i_reg;
    logic signed [15:0]       l_reg;
    logic signed [15:0]       r_reg;
    logic                     stop_reg;
    logic                     fin_reg;
    logic                     notify_reg;

    // Result register.
    logic                                out_valid_reg;
    logic signed [lfpd_pkg::DRIVE_W-1:0] out_left_reg;
    logic signed [lfpd_pkg::DRIVE_W-1:0] out_right_reg;
    logic                                out_stop_reg;
    logic [1:0]                          out_status_reg;
    logic                                out_fin_reg;
    logic                                out_alert_reg;
    logic                                out_notify_reg;
    logic signed [lfpd_pkg::ERR_W-1:0]   out_err_reg;

    // Shared multiplier.
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] prod;

    lfpd_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= 12'd700;
            gp_reg      <= 10'd60;
            gi_reg      <= 10'd3;
            gd_reg      <= 10'd40;
            two_lap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfpd_pkg::CFG_BASE_DRIVE:   base_reg    <= cfg_data[lfpd_pkg::BASE_W-1:0];
                lfpd_pkg::CFG_GAIN_P:       gp_reg      <= cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::CFG_GAIN_I:       gi_reg      <= cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::CFG_GAIN_D:       gd_reg      <= cfg_data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::CFG_TWO_LAP_MODE: two_lap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective gains and base drive after limiting.
    logic [lfpd_pkg::GAIN_W-1:0] gp_eff;
    logic [lfpd_pkg::GAIN_W-1:0] gi_eff;
    logic [lfpd_pkg::GAIN_W-1:0] gd_eff;
    logic [lfpd_pkg::BASE_W-1:0] base_eff;

    assign gp_eff = (gp_reg > 10'(lfpd_pkg::GAIN_LIM)) ? 10'(lfpd_pkg::GAIN_LIM) : gp_reg;
    assign gi_eff = (gi_reg > 10'(lfpd_pkg::GAIN_LIM)) ? 10'(lfpd_pkg::GAIN_LIM) : gi_reg;
    assign gd_eff = (gd_reg > 10'(lfpd_pkg::GAIN_LIM)) ? 10'(lfpd_pkg::GAIN_LIM) : gd_reg;
    assign base_eff = (base_reg > 12'(lfpd_pkg::DRIVE_MAX))
                    ? 12'(lfpd_pkg::DRIVE_MAX) : base_reg;

    // Weighted sum and count of the sensors that see the line.
    logic signed [8:0] wsum;
    logic [3:0]        wcnt;
    logic [7:0]        wsum_mag;

    always_comb
    begin
        wsum = '0;
        wcnt = '0;
        for (int i = 0; i < lfpd_pkg::SENSOR_W; i++)
        begin
            if (!bits_reg[i])
            begin
                wsum = wsum + 9'(lfpd_pkg::SENSOR_WEIGHT[i]);
                wcnt = wcnt + 4'd1;
            end
        end
        wsum_mag = wsum[8] ? 8'(-wsum) : wsum[7:0];
    end

    // Tick decision: error selection, loss handling, distance and alert.
    logic [5:0]             calc_mag;
    logic signed [6:0]      calc_val;
    logic                   all_white;
    logic [6:0]             lost_inc;
    logic [6:0]             lost_next;
    logic                   long_loss;
    lfpd_pkg::line_status_t status_c;
    logic signed [6:0]      err_c;
    logic [16:0]            dl_mag;
    logic [16:0]            dr_mag;
    logic [SW-1:0]          dist_sum;
    logic [DW-1:0]          dist_next;
    logic [7:0]             ticks_inc;
    logic                   given_next;
    logic                   ended_next;
    logic [7:0]             ticks_next;
    logic                   target_hit;
    logic signed [11:0]     integ_sum;
    logic signed [10:0]     integ_next;
    logic signed [7:0]      diff_c;

    always_comb
    begin
        calc_mag = prod[lfpd_pkg::SHIFT_CNT +: 6];
        calc_val = wsum[8] ? -7'(calc_mag) : 7'(calc_mag);
        all_white = (bits_reg == 8'hFF);
        lost_inc  = lost_reg + 7'd1;
        lost_next = all_white ? lost_inc : 7'd0;
        long_loss = 1'b0;
        status_c  = lfpd_pkg::ST_ON_LINE;
        err_c     = calc_val;
        if (all_white)
        begin
            if (lost_inc < 7'(lfpd_pkg::LOST_SHORT))
            begin
                status_c = lfpd_pkg::ST_SHORT;
                err_c    = prev_reg;
            end
            else if (lost_inc < 7'(lfpd_pkg::LOST_LONG))
            begin
                status_c = lfpd_pkg::ST_MEDIUM;
            end
            else
            begin
                status_c  = lfpd_pkg::ST_LONG;
                long_loss = 1'b1;
            end
        end

        // Absolute encoder counts, saturated at four laps.
        dl_mag    = dl_reg[15] ? ({1'b0, ~dl_reg} + 17'd1) : {1'b0, dl_reg};
        dr_mag    = dr_reg[15] ? ({1'b0, ~dr_reg} + 17'd1) : {1'b0, dr_reg};
        dist_sum  = SW'(dist_reg) + SW'(dl_mag) + SW'(dr_mag);
        dist_next = (dist_sum > SW'(lfpd_pkg::DIST_CAP))
                  ? DW'(lfpd_pkg::DIST_CAP) : dist_sum[DW-1:0];

        // Alert sequence in two-lap mode.
        ticks_inc  = (alert_ticks_reg == 8'hFF) ? alert_ticks_reg : alert_ticks_reg + 8'd1;
        given_next = given_reg;
        ended_next = ended_reg;
        ticks_next = alert_ticks_reg;
        if (two_lap_reg)
        begin
            if (given_reg && !ended_reg)
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= 8'(lfpd_pkg::ALERT_TICKS))
                    ended_next = 1'b1;
            end
            if (!given_reg && dist_next >= DW'(lfpd_pkg::LAP_COUNTS))
            begin
                given_next = 1'b1;
                ticks_next = 8'd0;
            end
        end
        target_hit = two_lap_reg ? (dist_next >= DW'(2 * lfpd_pkg::LAP_COUNTS))
                                 : (dist_next >= DW'(lfpd_pkg::LAP_COUNTS));
        if (target_hit && given_next)
            ended_next = 1'b1;

        // Clamped integral and error difference for the derivative.
        integ_sum = 12'(integ_reg) + 12'(err_c);
        if (integ_sum > INT_HI)
            integ_next = 11'(INT_HI);
        else if (integ_sum < INT_LO)
            integ_next = 11'(INT_LO);
        else
            integ_next = integ_sum[10:0];
        diff_c = 8'(err_c) - 8'(prev_reg);
    end

    // Magnitudes fed to the multiplier.
    logic [5:0]          err_mag;
    logic [8:0]          integ_mag;
    logic [6:0]          diff_mag;
    logic [15:0]         l_mag;
    logic [15:0]         r_mag;
    logic [6:0]          scale_f;

    assign err_mag   = err_reg[6] ? 6'(-err_reg) : err_reg[5:0];
    assign integ_mag = integ_reg[10] ? 9'(-integ_reg) : integ_reg[8:0];
    assign diff_mag  = diff_reg[7] ? 7'(-diff_reg) : diff_reg[6:0];
    assign l_mag     = l_reg[15] ? 16'(-l_reg) : l_reg;
    assign r_mag     = r_reg[15] ? 16'(-r_reg) : r_reg;
    assign scale_f   = (lost_reg < 7'(lfpd_pkg::SCALE_SPLIT))
                     ? 7'(lfpd_pkg::SCALE_NEAR) : 7'(lfpd_pkg::SCALE_FAR);

    // Operand selection for the shared multiplier, one product per step.
    always_comb
    begin
        unique case (state_reg)
            S_CALC:
            begin
                mul_a = MW'(wsum_mag);
                mul_b = MW'(lfpd_pkg::cnt_recip(wcnt));
            end
            S_P_MUL:
            begin
                mul_a = MW'(err_mag);
                mul_b = MW'(gp_eff);
            end
            S_P_DIV, S_D_DIV:
            begin
                mul_a = prod[MW-1:0];
                mul_b = MW'(lfpd_pkg::RECIP10);
            end
            S_I_MUL:
            begin
                mul_a = MW'(integ_mag);
                mul_b = MW'(gi_eff);
            end
            S_I_DIV:
            begin
                mul_a = prod[MW-1:0];
                mul_b = MW'(lfpd_pkg::RECIP10K);
            end
            S_D_MUL:
            begin
                mul_a = MW'(diff_mag);
                mul_b = MW'(gd_eff);
            end
            S_L_MUL:
            begin
                mul_a = MW'(l_mag);
                mul_b = MW'(scale_f);
            end
            S_R_MUL:
            begin
                mul_a = MW'(r_mag);
                mul_b = MW'(scale_f);
            end
            S_L_DIV, S_R_DIV:
            begin
                mul_a = prod[MW-1:0];
                mul_b = MW'(lfpd_pkg::RECIP100);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Signed PID sum and raw wheel drives.
    logic signed [15:0] p_term;
    logic signed [15:0] i_term;
    logic signed [15:0] d_term;
    logic signed [15:0] pid_sum;
    logic [12:0]        d_quot;
    logic [13:0]        scaled_mag;

    assign d_quot     = prod[lfpd_pkg::SHIFT10 +: 13];
    assign p_term     = err_reg[6] ? -16'(p_reg) : 16'(p_reg);
    assign i_term     = integ_reg[10] ? -16'(i_reg) : 16'(i_reg);
    assign d_term     = diff_reg[7] ? -16'(d_quot) : 16'(d_quot);
    assign pid_sum    = p_term + i_term + d_term;
    assign scaled_mag = prod[lfpd_pkg::SHIFT100 +: 14];

    // Sequencer, controller state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_reg        <= '0;
            integ_reg       <= '0;
            lost_reg        <= '0;
            dist_reg        <= '0;
            given_reg       <= 1'b0;
            ended_reg       <= 1'b0;
            alert_ticks_reg <= '0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // The result leaves on its transfer; the finish step reloads it itself.
            if (out_valid_reg && out_ch.ready && state_reg != S_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        bits_reg  <= in_ch.sensor_bits;
                        fail_reg  <= in_ch.read_failed;
                        dl_reg    <= in_ch.left_delta;
                        dr_reg    <= in_ch.right_delta;
                        state_reg <= S_CALC;
                    end
                end

                S_CALC:
                begin
                    state_reg <= S_DECIDE;
                end

                S_DECIDE:
                begin
                    l_reg      <= '0;
                    r_reg      <= '0;
                    fin_reg    <= 1'b0;
                    notify_reg <= 1'b0;
                    stop_reg   <= 1'b1;
                    err_reg    <= '0;
                    priority if (halted_reg)
                    begin
                        status_reg <= lfpd_pkg::ST_ON_LINE;
                        state_reg  <= S_FINISH;
                    end
                    else if (fail_reg)
                    begin
                        status_reg <= lfpd_pkg::ST_LONG;
                        state_reg  <= S_FINISH;
                    end
                    else if (long_loss)
                    begin
                        lost_reg   <= lost_next;
                        halted_reg <= 1'b1;
                        status_reg <= lfpd_pkg::ST_LONG;
                        state_reg  <= S_FINISH;
                    end
                    else
                    begin
                        lost_reg        <= lost_next;
                        dist_reg        <= dist_next;
                        given_reg       <= given_next;
                        ended_reg       <= ended_next;
                        alert_ticks_reg <= ticks_next;
                        status_reg      <= status_c;
                        err_reg         <= err_c;
                        if (target_hit)
                        begin
                            halted_reg <= 1'b1;
                            fin_reg    <= 1'b1;
                            notify_reg <= !two_lap_reg;
                            state_reg  <= S_FINISH;
                        end
                        else
                        begin
                            stop_reg <= 1'b0;
                            diff_reg <= diff_c;
                            if (status_c == lfpd_pkg::ST_ON_LINE)
                            begin
                                integ_reg <= integ_next;
                                prev_reg  <= calc_val;
                            end
                            state_reg <= S_P_MUL;
                        end
                    end
                end

                S_P_MUL:
                begin
                    state_reg <= S_P_DIV;
                end

                S_P_DIV:
                begin
                    state_reg <= S_I_MUL;
                end

                S_I_MUL:
                begin
                    p_reg     <= prod[lfpd_pkg::SHIFT10 +: 13];
                    state_reg <= S_I_DIV;
                end

                S_I_DIV:
                begin
                    state_reg <= S_D_MUL;
                end

                S_D_MUL:
                begin
                    i_reg     <= prod[lfpd_pkg::SHIFT10K +: 6];
                    state_reg <= S_D_DIV;
                end

                S_D_DIV:
                begin
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    l_reg     <= 16'(base_eff) + pid_sum;
                    r_reg     <= 16'(base_eff) - pid_sum;
                    state_reg <= (status_reg == lfpd_pkg::ST_MEDIUM) ? S_L_MUL : S_FINISH;
                end

                S_L_MUL:
                begin
                    state_reg <= S_L_DIV;
                end

                S_L_DIV:
                begin
                    state_reg <= S_R_MUL;
                end

                S_R_MUL:
                begin
                    l_reg     <= l_reg[15] ? -16'(scaled_mag) : 16'(scaled_mag);
                    state_reg <= S_R_DIV;
                end

                S_R_DIV:
                begin
                    state_reg <= S_R_END;
                end

                S_R_END:
                begin
                    r_reg     <= r_reg[15] ? -16'(scaled_mag) : 16'(scaled_mag);
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    // Load the result register once the previous result has gone.
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_left_reg   <= finish_drive(l_reg);
                        out_right_reg  <= finish_drive(r_reg);
                        out_stop_reg   <= stop_reg;
                        out_status_reg <= status_reg;
                        out_fin_reg    <= fin_reg;
                        out_alert_reg  <= given_reg && !ended_reg;
                        out_notify_reg <= notify_reg;
                        out_err_reg    <= err_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel ports.
    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.left_drive   = out_left_reg;
    assign out_ch.right_drive  = out_right_reg;
    assign out_ch.motor_stop   = out_stop_reg;
    assign out_ch.line_status  = out_status_reg;
    assign out_ch.run_finished = out_fin_reg;
    assign out_ch.alert_on     = out_alert_reg;
    assign out_ch.notify_stop  = out_notify_reg;
    assign out_ch.line_error   = out_err_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for line_follow_pid_drive_core: an internal model predicts each tick's drive result.
// Depends on lfpd_pkg, lfpd_in_if, lfpd_out_if and the core itself.

module tb;
    import lfpd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Weights of the eight sensors from left to right.
    localparam int LINE_WEIGHT [SENSOR_W] = '{-40, -28, -20, -15, 15, 20, 28, 40};

    typedef struct {
        logic [SENSOR_W-1:0]       sensor_bits;
        logic                      read_failed;
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
    } tick_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      motor_stop;
        line_status_t              line_status;
        logic                      run_finished;
        logic                      alert_on;
        logic                      notify_stop;
        logic signed [ERR_W-1:0]   line_error;
    } drive_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lfpd_in_if  in_ch ();
    lfpd_out_if out_ch ();

    line_follow_pid_drive_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Model copy of the configuration registers.
    int base_cfg;
    int kp_cfg;
    int ki_cfg;
    int kd_cfg;
    bit two_lap_cfg;

    // Model copy of the controller state.
    int held_error;
    int integ_sum;
    int lost_count;
    int odo_total;
    bit alert_started;
    bit alert_done;
    int alert_count;
    bit is_halted;

    drive_t pending_drives [$];
    drive_t want_res;

    int    sender_gap_pct;
    int    sink_stall_pct;
    int    ticks_sent;
    int    ignored_ticks;
    int    results_checked;
    int    fail_count;
    int    cycle_count;
    string finish_kind;

    always #CLK_HALF clk = ~clk;

    // Run limit in case the core stops responding.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_drives.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Packs one result; the alert flag always comes from the current state.
    function automatic drive_t make_result(input int lft, input int rgt, input bit stop,
                                           input line_status_t st, input bit fin,
                                           input bit notify, input int err);
        drive_t res;
        res.left_drive   = DRIVE_W'(lft);
        res.right_drive  = DRIVE_W'(rgt);
        res.motor_stop   = stop;
        res.line_status  = st;
        res.run_finished = fin;
        res.alert_on     = alert_started && !alert_done;
        res.notify_stop  = notify;
        res.line_error   = ERR_W'(err);
        return res;
    endfunction

    // Clamp to the drive range, then lift small forward drives to the floor.
    function automatic int limit_drive(input int v);
        if (v > DRIVE_MAX)
            v = DRIVE_MAX;
        else if (v < -DRIVE_MAX)
            v = -DRIVE_MAX;
        if (v > 0 && v < DRIVE_FLOOR)
            v = DRIVE_FLOOR;
        return v;
    endfunction

    // Works out the drive result of one tick and advances the model state.
    function automatic drive_t predict_drive(input tick_t t);
        int           sum;
        int           cnt;
        int           calc;
        int           err;
        int           dl;
        int           dr;
        int           target;
        int           kp;
        int           ki;
        int           kd;
        int           pid;
        int           base;
        int           lft;
        int           rgt;
        int           scale;
        line_status_t st;

        if (is_halted)
            return make_result(0, 0, 1'b1, ST_ON_LINE, 1'b0, 1'b0, 0);
        if (t.read_failed)
            return make_result(0, 0, 1'b1, ST_LONG, 1'b0, 1'b0, 0);

        // Weighted average over the sensors that see black.
        sum = 0;
        cnt = 0;
        for (int i = 0; i < SENSOR_W; i++)
        begin
            if (!t.sensor_bits[i])
            begin
                sum += LINE_WEIGHT[i];
                cnt++;
            end
        end
        calc = (cnt != 0) ? sum / cnt : 0;
        err  = calc;

        // Line-loss bookkeeping.
        if (t.sensor_bits == 8'hFF)
        begin
            lost_count++;
            if (lost_count < LOST_SHORT)
            begin
                err = held_error;
                st  = ST_SHORT;
            end
            else if (lost_count < LOST_LONG)
                st = ST_MEDIUM;
            else
            begin
                is_halted = 1'b1;
                return make_result(0, 0, 1'b1, ST_LONG, 1'b0, 1'b0, 0);
            end
        end
        else
        begin
            lost_count = 0;
            st         = ST_ON_LINE;
        end

        // Odometer from absolute encoder deltas.
        dl = t.left_delta;
        dr = t.right_delta;
        odo_total += (dl < 0) ? -dl : dl;
        odo_total += (dr < 0) ? -dr : dr;
        if (odo_total > DIST_CAP)
            odo_total = DIST_CAP;

        // One-lap alert in two-lap mode.
        target = two_lap_cfg ? 2 * LAP_COUNTS : LAP_COUNTS;
        if (two_lap_cfg)
        begin
            if (alert_started && !alert_done)
            begin
                if (alert_count < 255)
                    alert_count++;
                if (alert_count >= ALERT_TICKS)
                    alert_done = 1'b1;
            end
            if (!alert_started && odo_total >= LAP_COUNTS)
            begin
                alert_started = 1'b1;
                alert_count   = 0;
            end
        end

        if (odo_total >= target)
        begin
            if (alert_started)
                alert_done = 1'b1;
            is_halted = 1'b1;
            return make_result(0, 0, 1'b1, st, 1'b1, !two_lap_cfg, err);
        end

        // PID correction; each term truncates on its own.
        if (st == ST_ON_LINE)
        begin
            integ_sum += err;
            if (integ_sum > INTEG_LIM)
                integ_sum = INTEG_LIM;
            else if (integ_sum < -INTEG_LIM)
                integ_sum = -INTEG_LIM;
        end
        kp  = (kp_cfg > GAIN_LIM) ? GAIN_LIM : kp_cfg;
        ki  = (ki_cfg > GAIN_LIM) ? GAIN_LIM : ki_cfg;
        kd  = (kd_cfg > GAIN_LIM) ? GAIN_LIM : kd_cfg;
        pid = kp * err / 10 + ki * integ_sum / 1000 / 10 + kd * (err - held_error) / 10;
        if (st == ST_ON_LINE)
            held_error = calc;

        base = (base_cfg > DRIVE_MAX) ? DRIVE_MAX : base_cfg;
        lft  = base + pid;
        rgt  = base - pid;
        if (st == ST_MEDIUM)
        begin
            scale = (lost_count < SCALE_SPLIT) ? SCALE_NEAR : SCALE_FAR;
            lft   = lft * scale / 100;
            rgt   = rgt * scale / 100;
        end
        return make_result(limit_drive(lft), limit_drive(rgt), 1'b0, st, 1'b0, 1'b0, err);
    endfunction

    // ------------------------------------------------------------------
    // Result checking and sink pacing
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("Drive result transfer with no tick outstanding");
                fail_count++;
            end
            else
            begin
                want_res = pending_drives.pop_front();
                results_checked++;
                check_field("left_drive", want_res.left_drive, out_ch.left_drive);
                check_field("right_drive", want_res.right_drive, out_ch.right_drive);
                check_field("motor_stop", want_res.motor_stop, out_ch.motor_stop);
                check_field("line_status", want_res.line_status, out_ch.line_status);
                check_field("run_finished", want_res.run_finished, out_ch.run_finished);
                check_field("alert_on", want_res.alert_on, out_ch.alert_on);
                check_field("notify_stop", want_res.notify_stop, out_ch.notify_stop);
                check_field("line_error", want_res.line_error, out_ch.line_error);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic tick_t make_tick(input logic [SENSOR_W-1:0] bits, input logic fail,
                                        input logic signed [DELTA_W-1:0] dl,
                                        input logic signed [DELTA_W-1:0] dr);
        tick_t t;
        t.sensor_bits = bits;
        t.read_failed = fail;
        t.left_delta  = dl;
        t.right_delta = dr;
        return t;
    endfunction

    // Encoder change of a slow tick, kept small so the lap is far away.
    function automatic logic signed [DELTA_W-1:0] small_delta();
        return DELTA_W'(int'($urandom_range(0, 20)) - 10);
    endfunction

    // A sensor pattern with at least one black sensor.
    function automatic logic [SENSOR_W-1:0] line_pattern();
        logic [SENSOR_W-1:0] mask;
        int                  w;
        int                  pos;
        case ($urandom_range(0, 3))
            0:       mask = SENSOR_W'($urandom_range(1, 255));
            3:       mask = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
            default:
            begin
                w    = $urandom_range(1, 3);
                pos  = $urandom_range(0, SENSOR_W - w);
                mask = SENSOR_W'(((1 << w) - 1) << pos);
            end
        endcase
        return ~mask;
    endfunction

    function automatic tick_t noise_tick(input logic fail);
        return make_tick(SENSOR_W'($urandom), fail, DELTA_W'($urandom), DELTA_W'($urandom));
    endfunction

    task automatic set_traffic(input int gap_pct, input int stall_pct);
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
    endtask

    // Offers one tick, waits for its transfer and records the expected result.
    task automatic send_tick(input tick_t t);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sensor_bits <= t.sensor_bits;
        in_ch.read_failed <= t.read_failed;
        in_ch.left_delta  <= t.left_delta;
        in_ch.right_delta <= t.right_delta;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (is_halted)
            ignored_ticks++;
        pending_drives.push_back(predict_drive(t));
        ticks_sent++;
    endtask

    // Lets every outstanding result arrive and the core settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic load_config(input int base, input int kp, input int ki, input int kd,
                               input bit two_lap);
        drain_results();
        write_reg(CFG_BASE_DRIVE, base);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_TWO_LAP_MODE, two_lap);
        cfg_we      <= 1'b0;
        base_cfg    = base;
        kp_cfg      = kp;
        ki_cfg      = ki;
        kd_cfg      = kd;
        two_lap_cfg = two_lap;
    endtask

    task automatic load_random_config(input bit two_lap);
        load_config($urandom_range(0, 4095), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023), two_lap);
    endtask

    task automatic send_on_line();
        send_tick(make_tick(line_pattern(), 1'b0, small_delta(), small_delta()));
    endtask

    // A run of all-white ticks with some read failures mixed in, then back on the line.
    // The run never reaches the long-loss stop.
    task automatic send_loss_run(input int len);
        int done;
        done = 0;
        while (done < len && lost_count < LOST_LONG - 1)
        begin
            if ($urandom_range(0, 9) == 0)
                send_tick(noise_tick(1'b1));
            else
            begin
                send_tick(make_tick(8'hFF, 1'b0, small_delta(), small_delta()));
                done++;
            end
        end
        send_on_line();
    endtask

    // Mostly well-formed line following, with loss bursts, read failures and noise.
    task automatic send_mixed(input int n);
        int            sent;
        int            pick;
        int            len;
        logic [SENSOR_W-1:0] bits;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                        len = $urandom_range(1, LOST_SHORT - 1);
                    12, 13, 14, 15, 16:
                        len = $urandom_range(LOST_SHORT, SCALE_SPLIT - 1);
                    default:
                        len = $urandom_range(SCALE_SPLIT, LOST_LONG - 1);
                endcase
                send_loss_run(len);
                sent += len + 1;
            end
            else if (pick < 10)
            begin
                send_tick(noise_tick(1'b1));
                sent++;
            end
            else if (pick < 17)
            begin
                bits = SENSOR_W'($urandom);
                if (bits == 8'hFF && lost_count >= LOST_LONG - 1)
                    bits = 8'h7F;
                send_tick(make_tick(bits, 1'b0, small_delta(), small_delta()));
                sent++;
            end
            else
            begin
                send_on_line();
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Sensor extremes, truncating averages, short loss and read failures at reset settings.
    task automatic test_directed();
        logic [SENSOR_W-1:0] bits;
        send_tick(make_tick(8'h00, 1'b0, 16'sd0, 16'sd0));
        for (int i = 0; i < SENSOR_W; i++)
        begin
            bits = 8'hFF ^ (8'h01 << i);
            send_tick(make_tick(bits, 1'b0, 16'sd1, -16'sd1));
        end
        send_tick(make_tick(8'hFC, 1'b0, 16'sd3, 16'sd2));
        send_tick(make_tick(8'hF8, 1'b0, -16'sd2, 16'sd0));
        send_tick(make_tick(8'h1F, 1'b0, 16'sd0, -16'sd5));
        send_tick(make_tick(8'h7E, 1'b0, 16'sd4, 16'sd4));
        send_tick(make_tick(8'hAA, 1'b0, -16'sd1, -16'sd1));
        // Short loss holds the last on-line error.
        repeat (3) send_tick(make_tick(8'hFF, 1'b0, 16'sd2, 16'sd2));
        // Read failures drop even the largest encoder deltas.
        send_tick(make_tick(8'h00, 1'b1, 16'sh8000, 16'sh7FFF));
        send_tick(make_tick(8'hFF, 1'b1, 16'sh7FFF, 16'sh8000));
        send_on_line();
    endtask

    // Zero gains, over-range registers, the drive floor and the reset values.
    task automatic test_config_extremes();
        int sets [6][4] = '{
            '{0, 0, 0, 0},
            '{4095, 1023, 1023, 1023},
            '{1999, 999, 999, 999},
            '{60, 5, 0, 3},
            '{2000, 0, 999, 0},
            '{700, 60, 3, 40}
        };
        for (int s = 0; s < 6; s++)
        begin
            load_config(sets[s][0], sets[s][1], sets[s][2], sets[s][3], 1'b0);
            repeat (20) send_on_line();
        end
    endtask

    // Steady error on one side, then the other, drives the integral into both clamps.
    task automatic test_integral_clamp();
        load_config(1000, 100, 999, 50, 1'b0);
        repeat (16) send_tick(make_tick(8'hFE, 1'b0, small_delta(), small_delta()));
        repeat (30) send_tick(make_tick(8'h7F, 1'b0, small_delta(), small_delta()));
        repeat (4) send_tick(make_tick(8'hFE, 1'b0, small_delta(), small_delta()));
    endtask

    // Every loss band up to the last tick before the long-loss stop.
    task automatic test_line_loss();
        load_config(1500, 80, 20, 60, 1'b0);
        send_on_line();
        send_loss_run(LOST_LONG - 1);
        send_loss_run(LOST_SHORT - 1);
        send_loss_run(LOST_SHORT);
        send_loss_run(SCALE_SPLIT);
        send_loss_run($urandom_range(1, LOST_LONG - 1));
    endtask

    // Random traffic under three flow-control profiles, each with its own settings.
    task automatic test_random_traffic();
        set_traffic(7, 47);
        load_random_config(1'b0);
        send_mixed(120);
        set_traffic(47, 7);
        load_random_config(1'b0);
        send_mixed(120);
        set_traffic(0, 0);
        load_random_config(1'b0);
        send_mixed(120);
    endtask

    // Two-lap mode: first lap raises the alert, which times out; then one way of stopping.
    task automatic test_lap_and_stop();
        int need;
        int half;
        set_traffic(7, 47);
        load_random_config(1'b1);
        need = LAP_COUNTS - odo_total + $urandom_range(0, 3000);
        half = need / 2;
        send_tick(make_tick(line_pattern(), 1'b0, DELTA_W'(half), DELTA_W'(half - need)));
        send_mixed(260);

        case ($urandom_range(0, 2))
            0:
            begin
                finish_kind = "the second lap";
                need = 2 * LAP_COUNTS - odo_total + $urandom_range(0, 1000);
                half = need / 2;
                send_tick(make_tick(line_pattern(), 1'b0,
                                    DELTA_W'($urandom_range(0, 1) ? -half : half),
                                    DELTA_W'($urandom_range(0, 1) ? half - need : need - half)));
            end
            1:
            begin
                finish_kind = "a lap in one-lap mode";
                load_random_config(1'b0);
                send_on_line();
            end
            default:
            begin
                finish_kind = "a long line loss";
                while (!is_halted)
                    send_tick(make_tick(8'hFF, 1'b0, 16'sd0, 16'sd0));
            end
        endcase

        // Once stopped, the core ignores whatever arrives.
        set_traffic(0, 0);
        repeat (20) send_tick(noise_tick(1'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_BASE_DRIVE;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.sensor_bits = '1;
        in_ch.read_failed = 1'b0;
        in_ch.left_delta  = '0;
        in_ch.right_delta = '0;
        out_ch.ready      = 1'b0;

        base_cfg      = 700;
        kp_cfg        = 60;
        ki_cfg        = 3;
        kd_cfg        = 40;
        two_lap_cfg   = 1'b0;
        held_error    = 0;
        integ_sum     = 0;
        lost_count    = 0;
        odo_total     = 0;
        alert_started = 1'b0;
        alert_done    = 1'b0;
        alert_count   = 0;
        is_halted     = 1'b0;

        ticks_sent      = 0;
        ignored_ticks   = 0;
        results_checked = 0;
        fail_count      = 0;
        cycle_count     = 0;
        finish_kind     = "nothing";
        set_traffic(7, 47);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_integral_clamp();
        test_line_loss();
        test_random_traffic();
        test_lap_and_stop();
        drain_results();

        $display("Sent %0d control ticks (%0d after the stop) and checked %0d results.",
                 ticks_sent, ignored_ticks, results_checked);
        $display("Covered all loss bands, register extremes, the lap alert and a stop by %s.",
                 finish_kind);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lfpd_pkg.sv
src/lfpd_in_if.sv
src/lfpd_out_if.sv
src/lfpd_mul.sv
src/line_follow_pid_drive_core.sv
dv/tb.sv
